@@ rtl/kpp_pkg.sv @@
// shared types and constants of the knock port packer
package kpp_pkg;

  // field widths
  localparam int unsigned PortW      = 16;
  localparam int unsigned KBitsW     = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned AccW       = 23;
  localparam int unsigned HeldW      = 5;
  localparam int unsigned IdxW       = 17;
  localparam int unsigned SumW       = 34;
  localparam int unsigned MaxKnockBits = 16;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;

  // register reset values
  localparam logic [PortW-1:0]  PortOffsetRst = '0;
  localparam logic [KBitsW-1:0] KnockBitsRst  = 5'd8;

  // register word indexes
  localparam logic RegPortOffset = 1'b0;
  localparam logic RegKnockBits  = 1'b1;

  // input word
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } kpp_in_t;

  // output word
  typedef struct packed {
    logic [PortW-1:0] knock_port;
    logic             out_of_range;
    logic             last_of_run;
    logic             message_done;
  } kpp_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic drop;
    logic emit;
  } kpp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic discard;
    logic any_result;
    logic final_result;
    logic out_free;
  } kpp_status_t;

  // controller states
  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } kpp_state_e;

endpackage

@@ rtl/kpp_ctrl.sv @@
// controller: accepts bytes and steps the datapath through the knocks of each byte
module kpp_ctrl
  import kpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  kpp_status_t status_i,
  output kpp_cmd_t    cmd_o
);

  kpp_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (status_i.discard) begin
            cmd_o.drop = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = StEmit;
          end
        end
      end
      StEmit: begin
        if (!status_i.any_result) begin
          state_d = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.final_result) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/kpp_datapath.sv @@
// datapath: bit accumulator, knock counter, port adder and output register
module kpp_datapath
  import kpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PortW-1:0]  port_offset_i,
  input  logic [KBitsW-1:0] knock_bits_i,
  input  logic              cfg_clear_i,
  input  kpp_in_t           in_data_i,
  input  kpp_cmd_t          cmd_i,
  output kpp_status_t       status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kpp_out_t          out_data_o
);

  logic [AccW-1:0]  acc_q, acc_d;
  logic [HeldW-1:0] held_q, held_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             discard_q, discard_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  kpp_out_t         out_q, out_d;

  logic [KBitsW-1:0] k_eff;
  logic              have_group;
  logic              have_tail;
  logic [HeldW-1:0]  rem;
  logic [PortW-1:0]  value;
  logic [SumW-1:0]   port_sum;
  logic              err;
  logic              more;
  logic              final_res;
  logic [AccW-1:0]   rem_mask;

  // group size, zero acts as one and large values saturate
  always_comb begin
    if (knock_bits_i == '0) begin
      k_eff = KBitsW'(1);
    end else if (knock_bits_i > KBitsW'(MaxKnockBits)) begin
      k_eff = KBitsW'(MaxKnockBits);
    end else begin
      k_eff = knock_bits_i;
    end
  end

  // next group and its port
  assign have_group = held_q >= k_eff;
  assign have_tail  = last_q && (held_q != '0);
  assign rem        = held_q - k_eff;
  assign value      = have_group ? PortW'(acc_q >> rem) : acc_q[PortW-1:0];
  assign port_sum   = SumW'(port_offset_i) + SumW'(value) + (SumW'(idx_q) << k_eff);
  assign err        = |port_sum[SumW-1:PortW];
  assign more       = have_group && ((rem >= k_eff) || (last_q && (rem != '0)));
  assign final_res  = err || !more;
  assign rem_mask   = (AccW'(1) << rem) - AccW'(1);

  assign status_o.discard      = discard_q;
  assign status_o.any_result   = have_group || have_tail;
  assign status_o.final_result = final_res;
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

  // message state update
  always_comb begin
    acc_d     = acc_q;
    held_d    = held_q;
    idx_d     = idx_q;
    discard_d = discard_q;
    last_d    = last_q;
    if (cfg_clear_i) begin
      acc_d     = '0;
      held_d    = '0;
      idx_d     = '0;
      discard_d = 1'b0;
    end else if (cmd_i.drop) begin
      if (in_data_i.last_byte) begin
        acc_d     = '0;
        held_d    = '0;
        idx_d     = '0;
        discard_d = 1'b0;
      end
    end else if (cmd_i.load) begin
      acc_d  = {acc_q[AccW-ByteW-1:0], in_data_i.data_byte};
      held_d = held_q + HeldW'(ByteW);
      last_d = in_data_i.last_byte;
    end else if (cmd_i.emit) begin
      if (err || (final_res && last_q)) begin
        acc_d     = '0;
        held_d    = '0;
        idx_d     = '0;
        discard_d = err && !last_q;
      end else begin
        held_d = rem;
        acc_d  = acc_q & rem_mask;
        idx_d  = idx_q + IdxW'(1);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d        = 1'b1;
      out_d.knock_port   = err ? '0 : port_sum[PortW-1:0];
      out_d.out_of_range = err;
      out_d.last_of_run  = final_res;
      out_d.message_done = err || (final_res && last_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      held_q      <= '0;
      idx_q       <= '0;
      discard_q   <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      held_q      <= held_d;
      idx_q       <= idx_d;
      discard_q   <= discard_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/byte_to_knock_port_packer.sv @@
// Knock port packer top level: message bytes in, one knock port word per bit
// group out. Each accepted byte is loaded and then yields its results one at
// a time (a byte that yields no result still passes the emit state, and a byte
// dropped after an out-of-range error is taken without loading); with
// knock_bits of 1 a byte yields eight ports. The single port adder forms one
// knock a cycle while the output register is not held by a stall.
// No new byte is taken until the previous byte's results are all formed; the
// output register lets the next byte load while the last result waits.
// Registers: port offset at 0x0, knock_bits at 0x4; writing knock_bits drops
// the message in progress.
module byte_to_knock_port_packer
  import kpp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kpp_in_t             in_data_i,
  // output words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kpp_out_t            out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [PortW-1:0]  port_offset_q, port_offset_d;
  logic [KBitsW-1:0] knock_bits_q, knock_bits_d;
  logic              cfg_wr;
  logic              cfg_clear;
  logic              reg_idx;
  kpp_cmd_t          cmd;
  kpp_status_t       status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  // register write decode
  always_comb begin
    port_offset_d = port_offset_q;
    knock_bits_d  = knock_bits_q;
    cfg_clear     = 1'b0;
    if (cfg_wr) begin
      unique case (reg_idx)
        RegPortOffset: port_offset_d = pwdata[PortW-1:0];
        RegKnockBits: begin
          knock_bits_d = pwdata[KBitsW-1:0];
          cfg_clear    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegPortOffset: prdata = ApbDataW'(port_offset_q);
      RegKnockBits:  prdata = ApbDataW'(knock_bits_q);
      default:       prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_offset_q <= PortOffsetRst;
      knock_bits_q  <= KnockBitsRst;
    end else begin
      port_offset_q <= port_offset_d;
      knock_bits_q  <= knock_bits_d;
    end
  end

  // controller
  kpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  kpp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .port_offset_i (port_offset_q),
    .knock_bits_i  (knock_bits_q),
    .cfg_clear_i   (cfg_clear),
    .in_data_i     (in_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

@@ verif/byte_to_knock_port_packer_tb.sv @@
// self-checking testbench for the knock port packer
module byte_to_knock_port_packer_tb
  import kpp_pkg::*;
();

  localparam int unsigned PortMax     = 65535;
  localparam int unsigned ByteBits    = 8;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseBytes  = 30;
  localparam int unsigned RandPhases  = 8;

  typedef enum logic [1:0] {
    StallNone,
    StallCoin,
    StallHeavy,
    StallToggle
  } stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  kpp_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  kpp_out_t            out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // pending bytes and expected knock words
  kpp_in_t  byte_queue[$];
  kpp_out_t port_queue[$];
  kpp_out_t step_words[$];

  // predictor copy of registers and message state
  logic [PortW-1:0]  cfg_base  = PortOffsetRst;
  logic [KBitsW-1:0] cfg_kbits = KnockBitsRst;
  logic [AccW-1:0]   acc       = '0;
  int unsigned       held      = 0;
  logic [IdxW-1:0]   knock_idx = '0;
  logic              dropping  = 1'b0;

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned mode_left   = 0;
  int unsigned msg_left    = 0;
  stall_mode_e stall_mode  = StallNone;
  logic        in_taken    = 1'b0;
  kpp_out_t    want;

  byte_to_knock_port_packer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // message state back to idle
  function automatic void clear_message();
    acc       = '0;
    held      = 0;
    knock_idx = '0;
    dropping  = 1'b0;
  endfunction

  // one knock for a bit group; returns 0 when the port overflows
  function automatic bit form_knock(logic [AccW-1:0] grp, int unsigned k);
    longint unsigned sum;
    kpp_out_t w;
    sum = 64'(cfg_base) + 64'(grp) + (64'(knock_idx) << k);
    w = '0;
    if (sum > PortMax) begin
      w.out_of_range = 1'b1;
      w.last_of_run  = 1'b1;
      w.message_done = 1'b1;
      step_words.push_back(w);
      return 1'b0;
    end
    w.knock_port = sum[PortW-1:0];
    step_words.push_back(w);
    knock_idx = knock_idx + 1'b1;
    return 1'b1;
  endfunction

  // expected knock words for one accepted byte
  function automatic void pack_byte(kpp_in_t w);
    int unsigned k;
    logic [AccW-1:0] grp;
    bit ok;
    k = (cfg_kbits == 0) ? 1 : ((cfg_kbits > MaxKnockBits) ? MaxKnockBits : cfg_kbits);
    step_words.delete();
    ok = 1'b1;
    if (dropping) begin
      if (w.last_byte) clear_message();
      return;
    end
    acc  = {acc[AccW-ByteBits-1:0], w.data_byte};
    held = held + ByteBits;
    while (ok && held >= k) begin
      held = held - k;
      grp  = acc >> held;
      acc  = acc & ((AccW'(1) << held) - AccW'(1));
      ok   = form_knock(grp, k);
    end
    // leftover bits at message end, right aligned
    if (ok && w.last_byte && held > 0) begin
      grp  = acc;
      acc  = '0;
      held = 0;
      ok   = form_knock(grp, k);
    end
    if (!ok) begin
      clear_message();
      dropping = !w.last_byte;
    end else begin
      if (step_words.size() > 0) begin
        step_words[$].last_of_run = 1'b1;
        if (w.last_byte) step_words[$].message_done = 1'b1;
      end
      if (w.last_byte) clear_message();
    end
    foreach (step_words[i]) port_queue.push_back(step_words[i]);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic void queue_byte(logic [ByteW-1:0] b, logic l);
    kpp_in_t w;
    w.data_byte = b;
    w.last_byte = l;
    byte_queue.push_back(w);
  endfunction

  // register write: setup then access, predictor follows at the write edge
  task automatic reg_write(logic idx, logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == RegPortOffset) begin
      cfg_base = value[PortW-1:0];
    end else begin
      cfg_kbits = value[KBitsW-1:0];
      clear_message();
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for every byte sent and every knock word seen, then let the block settle
  task automatic drain();
    while (byte_queue.size() > 0 || in_valid_i || port_queue.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // byte sender: bursts with random gaps
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_data_i  <= byte_queue.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern in randomly chosen modes
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(8, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallCoin:  out_stall_i <= 1'($urandom_range(0, 1));
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= ~out_stall_i;
    endcase
  end

  // accepted bytes feed the predictor, accepted words are checked
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) pack_byte(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (port_queue.size() == 0) begin
        $error("unexpected word: knock_port %0d, out_of_range %0b",
               out_data_o.knock_port, out_data_o.out_of_range);
        mismatches++;
      end else begin
        want = port_queue.pop_front();
        check_field("knock_port", want.knock_port, out_data_o.knock_port);
        check_field("out_of_range", want.out_of_range, out_data_o.out_of_range);
        check_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
        check_field("message_done", want.message_done, out_data_o.message_done);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("byte_to_knock_port_packer: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned kb;
    int unsigned bp;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: single and multi byte messages
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hFF, 1'b1);
    drain();

    // top port offset, one bit a knock: overflow mid message, rest dropped
    reg_write(RegPortOffset, 32'd65535);
    reg_write(RegKnockBits, 32'd1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h3C, 1'b1);
    queue_byte(8'h80, 1'b1);
    drain();

    // widest groups: overflow on the last byte, leftover group
    reg_write(RegPortOffset, 32'd0);
    reg_write(RegKnockBits, 32'd16);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b1);
    queue_byte(8'hAB, 1'b1);
    drain();

    // zero group size acts as one bit: eight knocks from one byte
    reg_write(RegKnockBits, 32'd0);
    queue_byte(8'hC3, 1'b1);
    drain();

    // oversized group size acts as the maximum
    reg_write(RegKnockBits, 32'd31);
    reg_write(RegPortOffset, 32'd100);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h01, 1'b1);
    drain();

    // odd group size near the top of the port range
    reg_write(RegPortOffset, 32'd65000);
    reg_write(RegKnockBits, 32'd3);
    queue_byte(8'hE7, 1'b0);
    queue_byte(8'h00, 1'b1);
    drain();

    // port offset changed mid message
    reg_write(RegPortOffset, 32'd0);
    reg_write(RegKnockBits, 32'd5);
    queue_byte(8'h9D, 1'b0);
    drain();
    reg_write(RegPortOffset, 32'd40000);
    queue_byte(8'h42, 1'b1);
    drain();

    // same group size rewritten mid message drops the message
    queue_byte(8'h77, 1'b0);
    drain();
    reg_write(RegKnockBits, 32'd5);
    queue_byte(8'h11, 1'b1);
    drain();

    // random settings and messages, some messages span a setting change
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        kb = ($urandom_range(0, 9) == 0) ?
             (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31)) :
             $urandom_range(1, 16);
        reg_write(RegKnockBits, {27'($urandom), kb[KBitsW-1:0]});
      end
      bp = ($urandom_range(0, 3) == 0) ? $urandom_range(60000, 65535) :
           $urandom_range(0, 4000);
      reg_write(RegPortOffset, {16'($urandom), bp[PortW-1:0]});
      for (int n = 0; n < PhaseBytes; n++) begin
        if (msg_left == 0) begin
          msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) :
                     $urandom_range(1, 5);
        end
        msg_left--;
        queue_byte(8'($urandom_range(0, 255)), msg_left == 0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("byte_to_knock_port_packer: match");
    end else begin
      $display("byte_to_knock_port_packer: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kpp_pkg.sv
rtl/kpp_ctrl.sv
rtl/kpp_datapath.sv
rtl/byte_to_knock_port_packer.sv
verif/byte_to_knock_port_packer_tb.sv
